@@ hdl/wecs_pkg.sv @@
// Package for the wrap-extended cycle time split: widths, constants, types.
package wecs_pkg;

  // Counter and field widths
  localparam int CounterBits = 32;
  localparam int SampleW     = 32;
  localparam int RateW       = 10;
  localparam int SecW        = 45;
  localparam int SubW        = 10;
  localparam int TickW       = 55;
  localparam int TotalW      = 64;
  localparam int WrapW       = 32;

  localparam logic [SampleW-1:0] SampleMask =
    SampleW'((64'd1 << CounterBits) - 64'd1);

  localparam logic [RateW-1:0] RateReset = RateW'(168);
  localparam logic [RateW-1:0] RateOne   = RateW'(1);
  localparam logic [RateW-1:0] Kilo      = RateW'(1000);

  // Shared divider: two quotient bits per cycle
  localparam int DivBitsPerStep = 2;
  localparam int DivSteps       = TotalW / DivBitsPerStep;
  localparam int DivCntW        = $clog2(DivSteps);
  localparam logic [DivCntW-1:0] DivLastStep = DivCntW'(DivSteps - 1);

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV_RATE,
    ST_DIV_MS,
    ST_DIV_S,
    ST_DONE
  } state_t;

  // Divider request and response
  typedef struct packed {
    logic              start;
    logic [TotalW-1:0] dividend;
    logic [RateW-1:0]  divisor;
  } div_req_t;

  typedef struct packed {
    logic              busy;
    logic              done;
    logic [TotalW-1:0] quotient;
    logic [RateW-1:0]  remainder;
  } div_rsp_t;

endpackage

@@ hdl/wecs_if.sv @@
// Channel interfaces: counter samples in, split time out, rate configuration.
interface wecs_in_if import wecs_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [SampleW-1:0] counter_sample;

  modport source (output valid, output counter_sample, input ready);
  modport sink   (input valid, input counter_sample, output ready);
endinterface

interface wecs_out_if import wecs_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [SecW-1:0]   seconds;
  logic [SubW-1:0]   millis;
  logic [SubW-1:0]   micros;
  logic [TickW-1:0]  ms_tick;
  logic [TotalW-1:0] total_us;
  logic              wrapped;

  modport source (output valid, output seconds, output millis, output micros,
                  output ms_tick, output total_us, output wrapped, input ready);
  modport sink   (input valid, input seconds, input millis, input micros,
                  input ms_tick, input total_us, input wrapped, output ready);
endinterface

interface wecs_cfg_if import wecs_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [RateW-1:0] cycles_per_us;

  modport source (output valid, output cycles_per_us, input ready);
  modport sink   (input valid, input cycles_per_us, output ready);
endinterface

@@ hdl/wrap_extended_cycle_time_split.sv @@
// Top level: wrap tracking, divider sequencing and the result register.
// Each accepted counter sample is extended by the wrap count to a 64-bit cycle
// total, then split into seconds, milliseconds and microseconds by three passes
// through one shared radix-4 divider (total by the clock rate, then twice by
// 1000). Samples are not taken while a word is in work. The result register
// holds a finished word until it is taken, and the next sample may be
// accepted meanwhile; a word that finishes while the register is still full
// waits until it is taken. A rate of 0 is used as 1. The rate register is ready
// whenever reset is low and should be written only while the block is idle.
module wrap_extended_cycle_time_split import wecs_pkg::*; (
  input  logic clk,
  input  logic rst,
  wecs_in_if.sink    samples,
  wecs_out_if.source times,
  wecs_cfg_if.sink   cfg
);

  state_t state, state_next;

  logic [RateW-1:0]   cycles_per_us;
  logic [WrapW-1:0]   wrap_count;
  logic [SampleW-1:0] last_sample;

  logic [TotalW-1:0]  tus;
  logic [TickW-1:0]   tick;
  logic [SubW-1:0]    us;
  logic [SecW-1:0]    sec;
  logic [SubW-1:0]    ms;
  logic               wrap;

  logic               out_valid;
  logic [SecW-1:0]    out_seconds;
  logic [SubW-1:0]    out_millis;
  logic [SubW-1:0]    out_micros;
  logic [TickW-1:0]   out_ms_tick;
  logic [TotalW-1:0]  out_total_us;
  logic               out_wrapped;

  div_req_t div_req;
  div_rsp_t div_rsp;

  logic               accept;
  logic               load_out;
  logic [SampleW-1:0] sample_m;
  logic               wrap_now;
  logic [WrapW-1:0]   wrap_count_next;
  logic [TotalW-1:0]  total;
  logic [RateW-1:0]   rate;

  wecs_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  // Configuration register
  assign cfg.ready = !rst;

  always_ff @(posedge clk) begin
    if (rst) begin
      cycles_per_us <= RateReset;
    end else if (cfg.valid) begin
      cycles_per_us <= cfg.cycles_per_us;
    end
  end

  // Wrap detection and cycle total
  always_comb begin
    sample_m        = samples.counter_sample & SampleMask;
    wrap_now        = (sample_m < last_sample);
    wrap_count_next = wrap_now ? wrap_count + WrapW'(1) : wrap_count;
    total           = (TotalW'(wrap_count_next) << CounterBits) | TotalW'(sample_m);
    rate            = (cycles_per_us == '0) ? RateOne : cycles_per_us;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wrap_count  <= '0;
      last_sample <= '0;
    end else if (accept) begin
      wrap_count  <= wrap_count_next;
      last_sample <= sample_m;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:     if (samples.valid) state_next = ST_DIV_RATE;
      ST_DIV_RATE: if (div_rsp.done) state_next = ST_DIV_MS;
      ST_DIV_MS:   if (div_rsp.done) state_next = ST_DIV_S;
      ST_DIV_S:    if (div_rsp.done) state_next = ST_DONE;
      ST_DONE:     if (!out_valid || times.ready) state_next = ST_IDLE;
      default:     state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Sequencer outputs: divider requests and load strobes
  always_comb begin
    samples.ready    = 1'b0;
    div_req.start    = 1'b0;
    div_req.dividend = div_rsp.quotient;
    div_req.divisor  = Kilo;
    load_out         = 1'b0;
    case (state)
      ST_IDLE: begin
        samples.ready    = !rst;
        div_req.start    = samples.valid && !rst;
        div_req.dividend = total;
        div_req.divisor  = rate;
      end
      ST_DIV_RATE: div_req.start = div_rsp.done;
      ST_DIV_MS:   div_req.start = div_rsp.done;
      ST_DONE:     load_out = !out_valid || times.ready;
      default: begin
        div_req.start = 1'b0;
      end
    endcase
  end

  assign accept = samples.valid && samples.ready;

  // Intermediate results of the three passes
  always_ff @(posedge clk) begin
    if (accept) begin
      wrap <= wrap_now;
    end
    if (div_rsp.done) begin
      case (state)
        ST_DIV_RATE: tus <= div_rsp.quotient;
        ST_DIV_MS: begin
          tick <= div_rsp.quotient[TickW-1:0];
          us   <= div_rsp.remainder;
        end
        ST_DIV_S: begin
          sec <= div_rsp.quotient[SecW-1:0];
          ms  <= div_rsp.remainder;
        end
        default: begin
        end
      endcase
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (times.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_seconds  <= sec;
      out_millis   <= ms;
      out_micros   <= us;
      out_ms_tick  <= tick;
      out_total_us <= tus;
      out_wrapped  <= wrap;
    end
  end

  assign times.valid    = out_valid;
  assign times.seconds  = out_seconds;
  assign times.millis   = out_millis;
  assign times.micros   = out_micros;
  assign times.ms_tick  = out_ms_tick;
  assign times.total_us = out_total_us;
  assign times.wrapped  = out_wrapped;

`ifndef SYNTHESIS
  // Divider is never running while a sample can be taken
  a_idle_div_free: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE) |-> !div_rsp.busy)
    else $error("divider busy in idle");

  // A pass is only started on a free divider
  a_start_free: assert property (@(posedge clk) disable iff (rst)
    div_req.start |-> !div_rsp.busy)
    else $error("divider started while busy");

  // A load always leaves a valid word
  a_load_valid: assert property (@(posedge clk) disable iff (rst)
    load_out |=> out_valid)
    else $error("result load lost");

  // Sub-second fields stay in range
  a_sub_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_millis < Kilo && out_micros < Kilo))
    else $error("millis or micros out of range");
`endif

endmodule

@@ hdl/wecs_div.sv @@
// Shared restoring divider, 64-bit dividend by 10-bit divisor, two bits a cycle.
module wecs_div import wecs_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  div_req_t req,
  output div_rsp_t rsp
);

  logic               busy;
  logic               done;
  logic [DivCntW-1:0] cnt;
  logic [TotalW-1:0]  quo;
  logic [RateW-1:0]   rem;
  logic [RateW-1:0]   dvs;

  // Two dependent compare-subtract steps
  logic [RateW:0]   r1, r2;
  logic             b1, b2;
  logic [RateW-1:0] rem1, rem2;

  always_comb begin
    r1   = {rem, quo[TotalW-1]};
    b1   = (r1 >= {1'b0, dvs});
    rem1 = b1 ? RateW'(r1 - {1'b0, dvs}) : r1[RateW-1:0];
    r2   = {rem1, quo[TotalW-2]};
    b2   = (r2 >= {1'b0, dvs});
    rem2 = b2 ? RateW'(r2 - {1'b0, dvs}) : r2[RateW-1:0];
  end

  // Control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (busy) begin
        cnt <= cnt + DivCntW'(1);
        if (cnt == DivLastStep) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end else if (req.start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end
    end
  end

  // Datapath: quotient bits shift in as dividend bits shift out
  always_ff @(posedge clk) begin
    if (busy) begin
      quo <= {quo[TotalW-3:0], b1, b2};
      rem <= rem2;
    end else if (req.start) begin
      quo <= req.dividend;
      rem <= '0;
      dvs <= req.divisor;
    end
  end

  assign rsp.busy      = busy;
  assign rsp.done      = done;
  assign rsp.quotient  = quo;
  assign rsp.remainder = rem;

endmodule
